@@ rtl/h2rgb_pkg.sv @@
// shared types and constants for the hue to led pulse encoder
`timescale 1ns / 1ps

package h2rgb_pkg;

  // led word queue between the color front and the pulse serializer
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  // pulse slots per led
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned SLOT_W       = $clog2(BITS_PER_LED);

  localparam int unsigned HUE_W   = 9;
  localparam int unsigned BRIGHT_W = 9;
  localparam int unsigned CODE_W  = 16;

  localparam logic [HUE_W-1:0] HUE_LIMIT = 9'd360;
  localparam logic [5:0]       SEXT_SPAN = 6'd60;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd51;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_ONE_CODE   = 2'd1,
    REG_ZERO_CODE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEXT_R_FULL_G_UP   = 3'd0,
    SEXT_G_FULL_R_DOWN = 3'd1,
    SEXT_G_FULL_B_UP   = 3'd2,
    SEXT_B_FULL_G_DOWN = 3'd3,
    SEXT_B_FULL_R_UP   = 3'd4,
    SEXT_R_FULL_B_DOWN = 3'd5
  } sextant_t;

  // color in wire order: green, red, blue
  typedef struct packed {
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } grb_t;

  typedef struct packed {
    grb_t color;
    logic last_frame;
  } led_word_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic logic [7:0] sat8(input logic [8:0] v);
    logic [7:0] res;
    res = v[8] ? 8'hff : v[7:0];
    return res;
  endfunction

endpackage

@@ rtl/h2rgb_front.sv @@
// color front: takes hues, builds the grb color and keeps the per-led color store
`timescale 1ns / 1ps

module h2rgb_front #(
  parameter int unsigned NUM_LEDS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [h2rgb_pkg::HUE_W-1:0]         hue,
  input  logic [h2rgb_pkg::BRIGHT_W-1:0]      brightness,
  input  logic                                pop,
  output logic                                push,
  output h2rgb_pkg::led_word_t                push_word
);

  localparam int unsigned POS_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_LEDS - 1);

  // credits cover every item from acceptance until the serializer pops it
  logic [h2rgb_pkg::CNT_W-1:0] credit_cnt;
  logic [h2rgb_pkg::CNT_W-1:0] credit_cnt_next;
  logic                        accept;

  logic [POS_W-1:0] led_pos;

  // stage 1: captured item
  logic                        s1_valid;
  logic [h2rgb_pkg::HUE_W-1:0] s1_hue;
  logic [POS_W-1:0]            s1_pos;
  logic                        s1_last;

  // stage 2: sextant and products
  logic                        s2_valid;
  logic [POS_W-1:0]            s2_pos;
  logic                        s2_last;
  logic                        s2_in_range;
  h2rgb_pkg::sextant_t         s2_sext;
  logic [18:0]                 s2_up_p;
  logic [18:0]                 s2_down_p;
  logic [16:0]                 s2_full_p;

  h2rgb_pkg::sextant_t         sext;
  logic [h2rgb_pkg::HUE_W-1:0] sext_start;
  logic [5:0]                  frac;
  logic [5:0]                  frac_down;
  logic [9:0]                  up_lin;
  logic [9:0]                  down_lin;
  logic [18:0]                 up_p;
  logic [18:0]                 down_p;
  logic [16:0]                 full_p;

  // stage 3: store access
  logic [7:0]       lvl_up;
  logic [7:0]       lvl_down;
  logic [7:0]       lvl_full;
  h2rgb_pkg::grb_t  new_color;

  logic [23:0]      color_mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] led_written;

  logic             s3_valid;
  logic             s3_new;
  logic             s3_hit;
  logic             s3_last;
  h2rgb_pkg::grb_t  s3_color;
  logic [23:0]      rd_color;

  assign in_ready = credit_cnt < h2rgb_pkg::CNT_W'(h2rgb_pkg::QDEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    case ({accept, pop})
      2'b10:   credit_cnt_next = credit_cnt + 1'b1;
      2'b01:   credit_cnt_next = credit_cnt - 1'b1;
      default: credit_cnt_next = credit_cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_cnt <= '0;
      led_pos    <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
    end else begin
      credit_cnt <= credit_cnt_next;
      if (accept) begin
        led_pos <= (led_pos == LAST_POS) ? '0 : led_pos + 1'b1;
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hue  <= hue;
      s1_pos  <= led_pos;
      s1_last <= (led_pos == LAST_POS);
    end
  end

  // sextant search and channel products
  always_comb begin
    if (s1_hue >= 9'd300) begin
      sext = h2rgb_pkg::SEXT_R_FULL_B_DOWN;
      sext_start = 9'd300;
    end else if (s1_hue >= 9'd240) begin
      sext = h2rgb_pkg::SEXT_B_FULL_R_UP;
      sext_start = 9'd240;
    end else if (s1_hue >= 9'd180) begin
      sext = h2rgb_pkg::SEXT_B_FULL_G_DOWN;
      sext_start = 9'd180;
    end else if (s1_hue >= 9'd120) begin
      sext = h2rgb_pkg::SEXT_G_FULL_B_UP;
      sext_start = 9'd120;
    end else if (s1_hue >= 9'd60) begin
      sext = h2rgb_pkg::SEXT_G_FULL_R_DOWN;
      sext_start = 9'd60;
    end else begin
      sext = h2rgb_pkg::SEXT_R_FULL_G_UP;
      sext_start = 9'd0;
    end
    frac      = 6'(s1_hue - sext_start);
    frac_down = h2rgb_pkg::SEXT_SPAN - frac;
    // 255 * f * b / 15360 equals 17 * f * b / 1024
    up_lin    = {frac, 4'b0} + {4'b0, frac};
    down_lin  = {frac_down, 4'b0} + {4'b0, frac_down};
    up_p      = {9'b0, up_lin} * {10'b0, brightness};
    down_p    = {9'b0, down_lin} * {10'b0, brightness};
    full_p    = {brightness, 8'b0} - {8'b0, brightness};
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_pos      <= s1_pos;
      s2_last     <= s1_last;
      s2_in_range <= s1_hue < h2rgb_pkg::HUE_LIMIT;
      s2_sext     <= sext;
      s2_up_p     <= up_p;
      s2_down_p   <= down_p;
      s2_full_p   <= full_p;
    end
  end

  always_comb begin
    lvl_up   = h2rgb_pkg::sat8(s2_up_p[18:10]);
    lvl_down = h2rgb_pkg::sat8(s2_down_p[18:10]);
    lvl_full = h2rgb_pkg::sat8(s2_full_p[16:8]);
    new_color = '0;
    case (s2_sext)
      h2rgb_pkg::SEXT_R_FULL_G_UP: begin
        new_color.r = lvl_full;
        new_color.g = lvl_up;
      end
      h2rgb_pkg::SEXT_G_FULL_R_DOWN: begin
        new_color.r = lvl_down;
        new_color.g = lvl_full;
      end
      h2rgb_pkg::SEXT_G_FULL_B_UP: begin
        new_color.g = lvl_full;
        new_color.b = lvl_up;
      end
      h2rgb_pkg::SEXT_B_FULL_G_DOWN: begin
        new_color.g = lvl_down;
        new_color.b = lvl_full;
      end
      h2rgb_pkg::SEXT_B_FULL_R_UP: begin
        new_color.r = lvl_up;
        new_color.b = lvl_full;
      end
      default: begin
        new_color.r = lvl_full;
        new_color.b = lvl_down;
      end
    endcase
  end

  // read and write of an item happen in the same stage, so a later item
  // for the same led always sees the earlier write
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      if (s2_in_range) begin
        color_mem[s2_pos] <= new_color;
      end else begin
        rd_color <= color_mem[s2_pos];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_written <= '0;
    end else if (s2_valid && s2_in_range) begin
      led_written[s2_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_new   <= s2_in_range;
      s3_hit   <= led_written[s2_pos];
      s3_last  <= s2_last;
      s3_color <= new_color;
    end
  end

  assign push = s3_valid;

  always_comb begin
    push_word.last_frame = s3_last;
    if (s3_new) begin
      push_word.color = s3_color;
    end else if (s3_hit) begin
      push_word.color = rd_color;
    end else begin
      push_word.color = '0;
    end
  end

endmodule

@@ rtl/h2rgb_fifo.sv @@
// short led word queue between front and serializer
`timescale 1ns / 1ps

module h2rgb_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  h2rgb_pkg::led_word_t    push_word,
  input  logic                    pop,
  output h2rgb_pkg::led_word_t    head,
  output h2rgb_pkg::fifo_status_t status
);

  h2rgb_pkg::led_word_t               slots [h2rgb_pkg::QDEPTH];
  logic [h2rgb_pkg::QPTR_W-1:0]       wr_ptr;
  logic [h2rgb_pkg::QPTR_W-1:0]       rd_ptr;
  logic [h2rgb_pkg::CNT_W-1:0]        count;

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == h2rgb_pkg::CNT_W'(h2rgb_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

@@ rtl/h2rgb_serial.sv @@
// pulse serializer: shifts a grb word out as 24 compare codes, msb first
`timescale 1ns / 1ps

module h2rgb_serial (
  input  logic                           clk,
  input  logic                           rst,
  input  h2rgb_pkg::fifo_status_t        q_status,
  input  h2rgb_pkg::led_word_t           q_head,
  output logic                           pop,
  input  logic [h2rgb_pkg::CODE_W-1:0]   one_bit_code,
  input  logic [h2rgb_pkg::CODE_W-1:0]   zero_bit_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [h2rgb_pkg::CODE_W-1:0]   pulse_code,
  output logic                           last_of_led,
  output logic                           last_of_frame
);

  logic                          busy;
  logic [23:0]                   shreg;
  logic [h2rgb_pkg::SLOT_W-1:0]  bit_cnt;
  logic                          frame_flag;
  logic                          slot_free;
  logic                          emit;
  logic                          final_bit;

  assign slot_free = !out_valid || out_ready;
  assign emit      = busy && slot_free;
  assign final_bit = (bit_cnt == h2rgb_pkg::SLOT_W'(h2rgb_pkg::BITS_PER_LED - 1));
  // next word loads in the same cycle the last slot goes out
  assign pop       = !q_status.empty && (!busy || (emit && final_bit));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && final_bit) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg      <= q_head.color;
      bit_cnt    <= '0;
      frame_flag <= q_head.last_frame;
    end else if (emit) begin
      shreg   <= {shreg[22:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end
    if (emit) begin
      pulse_code    <= shreg[23] ? one_bit_code : zero_bit_code;
      last_of_led   <= final_bit;
      last_of_frame <= final_bit && frame_flag;
    end
  end

endmodule

@@ rtl/hue_to_rgb_led_pulse_encoder.sv @@
// top level: hue to grb led pulse code encoder with config registers
//
//   channel   signals                                    direction
//   config    cfg_we, cfg_index, cfg_data                in, write only
//   hue in    in_valid, in_ready, hue                    in, valid/ready
//   pulse out out_valid, out_ready, pulse_code,
//             last_of_led, last_of_frame                 out, valid/ready
//
// each item yields 24 pulse codes, one per cycle when out_ready stays high,
// so the sustained hue rate is set by the serializer
// an accepted item passes the 3 front stages, the queue, the serializer shift
// register and the output register before its first code appears
// in_ready drops once 4 items are accepted but not yet taken by the serializer
// reset is synchronous; the per-led written flags all clear at once, no
// clearing pass
`timescale 1ns / 1ps

module hue_to_rgb_led_pulse_encoder #(
  parameter int unsigned NUM_LEDS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [h2rgb_pkg::CODE_W-1:0]  cfg_data,
  // hue items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [h2rgb_pkg::HUE_W-1:0]   hue,
  // pulse code items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [h2rgb_pkg::CODE_W-1:0]  pulse_code,
  output logic                          last_of_led,
  output logic                          last_of_frame
);

  // config registers
  logic [h2rgb_pkg::BRIGHT_W-1:0] brightness;
  logic [h2rgb_pkg::CODE_W-1:0]   one_bit_code;
  logic [h2rgb_pkg::CODE_W-1:0]   zero_bit_code;

  // front to queue to serializer
  logic                    q_push;
  h2rgb_pkg::led_word_t    q_push_word;
  logic                    q_pop;
  h2rgb_pkg::led_word_t    q_head;
  h2rgb_pkg::fifo_status_t q_status;

  // writes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= h2rgb_pkg::BRIGHT_RESET;
      one_bit_code  <= '0;
      zero_bit_code <= '0;
    end else if (cfg_we) begin
      case (h2rgb_pkg::cfg_reg_t'(cfg_index))
        h2rgb_pkg::REG_BRIGHTNESS: brightness    <= cfg_data[h2rgb_pkg::BRIGHT_W-1:0];
        h2rgb_pkg::REG_ONE_CODE:   one_bit_code  <= cfg_data;
        h2rgb_pkg::REG_ZERO_CODE:  zero_bit_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: sextant, scaling, color store, credit count
  h2rgb_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .brightness (brightness),
    .pop        (q_pop),
    .push       (q_push),
    .push_word  (q_push_word)
  );

  // queue of finished led words
  h2rgb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_push_word),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // back: one pulse code per cycle while out_ready stays high
  h2rgb_serial u_serial (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_head        (q_head),
    .pop           (q_pop),
    .one_bit_code  (one_bit_code),
    .zero_bit_code (zero_bit_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pulse_code    (pulse_code),
    .last_of_led   (last_of_led),
    .last_of_frame (last_of_frame)
  );

`ifndef NO_ASSERTIONS
  // credits must keep the queue from overflowing
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_status.full))
    else $error("led word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("led word popped from empty queue");

  a_frame_end_on_led_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_frame) |-> last_of_led)
    else $error("frame end flagged off an led boundary");
`endif

endmodule

@@ test/hue_to_rgb_led_pulse_encoder_tb.sv @@
// self-checking testbench: hue items in, grb pulse codes out, checked against a predictor
`timescale 1ns / 1ps

module hue_to_rgb_led_pulse_encoder_tb;

  localparam int unsigned NUM_LEDS       = 8;
  // no-progress cycles before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // long receiver stall, well past what the block can buffer
  localparam int unsigned HOLD_CYCLES    = 400;
  // time for the pipeline to empty after the last code, with margin
  localparam int unsigned SETTLE_CYCLES  = 10;

  // one expected pulse code slot
  typedef struct packed {
    logic [h2rgb_pkg::CODE_W-1:0] code;
    logic                         led_end;
    logic                         frame_end;
  } pulse_slot_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [1:0]                   cfg_index = '0;
  logic [h2rgb_pkg::CODE_W-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [h2rgb_pkg::HUE_W-1:0]  hue = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [h2rgb_pkg::CODE_W-1:0] pulse_code;
  logic                         last_of_led;
  logic                         last_of_frame;

  // predictor copy of the registers and per-led state
  logic [h2rgb_pkg::BRIGHT_W-1:0] pred_brightness = h2rgb_pkg::BRIGHT_RESET;
  logic [h2rgb_pkg::CODE_W-1:0]   pred_one_code   = '0;
  logic [h2rgb_pkg::CODE_W-1:0]   pred_zero_code  = '0;
  int unsigned                    pred_led_pos    = 0;
  h2rgb_pkg::grb_t                pred_colors [NUM_LEDS];

  logic [h2rgb_pkg::HUE_W-1:0] hue_backlog [$];     // hues waiting to be offered
  pulse_slot_t                 pulses_expected [$]; // pulse codes still owed by the block

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_seen    = 0;
  int unsigned hold_cnt      = 0;
  int unsigned error_count   = 0;
  int unsigned stall_cycles  = 0;

  hue_to_rgb_led_pulse_encoder #(
    .NUM_LEDS(NUM_LEDS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .hue          (hue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pulse_code   (pulse_code),
    .last_of_led  (last_of_led),
    .last_of_frame(last_of_frame)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // color predictor
  // ---------------------------------------------------------------------------

  // channel level clipped to 8 bits, brightness above 256 can overshoot
  function automatic logic [7:0] clip_level(input int unsigned v);
    logic [7:0] lvl;
    lvl = (v > 255) ? 8'hff : v[7:0];
    return lvl;
  endfunction

  // one hue in 0..359 to a grb color at the given q8 brightness
  function automatic h2rgb_pkg::grb_t hue_to_grb(input logic [h2rgb_pkg::HUE_W-1:0] h,
                                                input logic [h2rgb_pkg::BRIGHT_W-1:0] bright);
    int unsigned          hv;
    int unsigned          bv;
    int unsigned          frac;
    logic [7:0]           full;
    logic [7:0]           up;
    logic [7:0]           down;
    h2rgb_pkg::sextant_t  sext;
    h2rgb_pkg::grb_t      c;
    hv   = h;
    bv   = bright;
    sext = h2rgb_pkg::sextant_t'(hv / h2rgb_pkg::SEXT_SPAN);
    frac = hv - (hv / h2rgb_pkg::SEXT_SPAN) * h2rgb_pkg::SEXT_SPAN;
    // full channel uses a plain q8 multiply, ramps divide by 60 * 256
    full = clip_level((255 * bv) >> 8);
    up   = clip_level((255 * frac * bv) / 15360);
    down = clip_level((255 * (h2rgb_pkg::SEXT_SPAN - frac) * bv) / 15360);
    c    = '0;
    case (sext)
      h2rgb_pkg::SEXT_R_FULL_G_UP: begin
        c.r = full;
        c.g = up;
      end
      h2rgb_pkg::SEXT_G_FULL_R_DOWN: begin
        c.r = down;
        c.g = full;
      end
      h2rgb_pkg::SEXT_G_FULL_B_UP: begin
        c.g = full;
        c.b = up;
      end
      h2rgb_pkg::SEXT_B_FULL_G_DOWN: begin
        c.g = down;
        c.b = full;
      end
      h2rgb_pkg::SEXT_B_FULL_R_UP: begin
        c.r = up;
        c.b = full;
      end
      default: begin
        c.r = full;
        c.b = down;
      end
    endcase
    return c;
  endfunction

  // an accepted hue: update the led's color if in range and queue its 24 pulse codes
  task automatic predict_led_pulses(input logic [h2rgb_pkg::HUE_W-1:0] h);
    h2rgb_pkg::grb_t c;
    pulse_slot_t     slot;
    int unsigned     pos;
    pos = pred_led_pos;
    // out-of-range hue re-sends whatever the led already holds
    if (h < h2rgb_pkg::HUE_LIMIT) begin
      pred_colors[pos] = hue_to_grb(h, pred_brightness);
    end
    c = pred_colors[pos];
    // wire order is green, red, blue, msb first
    for (int k = 0; k < h2rgb_pkg::BITS_PER_LED; k++) begin
      slot.code      = c[h2rgb_pkg::BITS_PER_LED - 1 - k] ? pred_one_code : pred_zero_code;
      slot.led_end   = (k == h2rgb_pkg::BITS_PER_LED - 1);
      slot.frame_end = (k == h2rgb_pkg::BITS_PER_LED - 1) && (pos == NUM_LEDS - 1);
      pulses_expected.push_back(slot);
    end
    // frame wraps back to the first led
    pred_led_pos = (pos == NUM_LEDS - 1) ? 0 : pos + 1;
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [h2rgb_pkg::CODE_W-1:0] got,
                                 input logic [h2rgb_pkg::CODE_W-1:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // hue driver: offers items from the backlog, idles at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // item taken at this edge, predict its pulse codes now
      if (in_valid && in_ready) begin
        predict_led_pulses(hue);
      end
      // valid stays up with the same hue until taken
      if (!in_valid || in_ready) begin
        if (hue_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          hue      <= hue_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pulse receiver: random ready, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holds_asked != holds_seen) begin
      holds_seen <= holds_asked;
      hold_cnt   <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // pulse monitor: every accepted code against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_slot_t want;
    if (!rst && out_valid && out_ready) begin
      if (pulses_expected.size() == 0) begin
        report_mismatch("unexpected pulse_code", pulse_code, '0);
      end else begin
        want = pulses_expected.pop_front();
        if (pulse_code !== want.code) begin
          report_mismatch("pulse_code", pulse_code, want.code);
        end
        if (last_of_led !== want.led_end) begin
          report_mismatch("last_of_led", h2rgb_pkg::CODE_W'(last_of_led),
                          h2rgb_pkg::CODE_W'(want.led_end));
        end
        if (last_of_frame !== want.frame_end) begin
          report_mismatch("last_of_frame", h2rgb_pkg::CODE_W'(last_of_frame),
                          h2rgb_pkg::CODE_W'(want.frame_end));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends a run that stops making progress
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequencing
  // ---------------------------------------------------------------------------

  // register write, mirrored into the predictor
  task automatic write_reg(input h2rgb_pkg::cfg_reg_t idx,
                           input logic [h2rgb_pkg::CODE_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      h2rgb_pkg::REG_BRIGHTNESS: pred_brightness = data[h2rgb_pkg::BRIGHT_W-1:0];
      h2rgb_pkg::REG_ONE_CODE:   pred_one_code   = data;
      h2rgb_pkg::REG_ZERO_CODE:  pred_zero_code  = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_levels(input logic [h2rgb_pkg::BRIGHT_W-1:0] bright,
                            input logic [h2rgb_pkg::CODE_W-1:0] one_code,
                            input logic [h2rgb_pkg::CODE_W-1:0] zero_code);
    write_reg(h2rgb_pkg::REG_BRIGHTNESS, h2rgb_pkg::CODE_W'(bright));
    write_reg(h2rgb_pkg::REG_ONE_CODE, one_code);
    write_reg(h2rgb_pkg::REG_ZERO_CODE, zero_code);
  endtask

  // wait for every item taken and every code delivered, then let the pipe settle
  task automatic wait_until_drained();
    while (hue_backlog.size() != 0 || in_valid || pulses_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly in-range hues, some out-of-range ones that re-send the stored color
  task automatic queue_random_hues(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        hue_backlog.push_back(h2rgb_pkg::HUE_W'($urandom_range(511, 360)));
      end else begin
        hue_backlog.push_back(h2rgb_pkg::HUE_W'($urandom_range(359, 0)));
      end
    end
  endtask

  initial begin
    logic [h2rgb_pkg::HUE_W-1:0] sextant_edges [12];
    for (int i = 0; i < NUM_LEDS; i++) begin
      pred_colors[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sender idles a little, receiver a lot
    send_idle_pct = 23;
    recv_idle_pct = 65;

    // reset levels, and an out-of-range hue on a led never written (black)
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(0));
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(400));
    wait_until_drained();

    // full brightness, extreme codes, every sextant boundary
    set_levels(9'd256, 16'hffff, 16'h0000);
    sextant_edges = '{9'd0, 9'd59, 9'd60, 9'd119, 9'd120, 9'd179,
                      9'd180, 9'd239, 9'd240, 9'd299, 9'd300, 9'd359};
    foreach (sextant_edges[i]) begin
      hue_backlog.push_back(sextant_edges[i]);
    end
    // boundary and top of the out-of-range band, both on written leds
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(360));
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(511));
    wait_until_drained();

    // brightness past full, channels must saturate
    set_levels(9'd511, 16'h0001, 16'hfffe);
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(30));
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(90));
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(200));
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(330));
    wait_until_drained();

    // zero brightness, everything black
    write_reg(h2rgb_pkg::REG_BRIGHTNESS, h2rgb_pkg::CODE_W'(0));
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(45));
    hue_backlog.push_back(h2rgb_pkg::HUE_W'(280));
    wait_until_drained();

    // random part, receiver holds off so the input side backs up
    set_levels(9'd128, 16'hffff, 16'h0000);
    holds_asked++;
    queue_random_hues(60);
    wait_until_drained();

    set_levels(h2rgb_pkg::BRIGHT_W'($urandom_range(256, 0)), h2rgb_pkg::CODE_W'($urandom),
               h2rgb_pkg::CODE_W'($urandom));
    queue_random_hues(60);
    wait_until_drained();

    // the other way round
    send_idle_pct = 65;
    recv_idle_pct = 23;
    set_levels(h2rgb_pkg::BRIGHT_W'($urandom_range(511, 0)), h2rgb_pkg::CODE_W'($urandom),
               h2rgb_pkg::CODE_W'($urandom));
    queue_random_hues(100);
    wait_until_drained();

    // no idling at all, back-to-back items
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_levels(9'd256, h2rgb_pkg::CODE_W'($urandom), h2rgb_pkg::CODE_W'($urandom));
    queue_random_hues(100);
    wait_until_drained();

    set_levels(h2rgb_pkg::BRIGHT_W'($urandom_range(511, 1)), h2rgb_pkg::CODE_W'($urandom),
               h2rgb_pkg::CODE_W'($urandom));
    holds_asked++;
    queue_random_hues(80);
    wait_until_drained();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
